@@ design/rational_arith_unit_top_macros.svh @@
// Assertion macros shared by the rational arithmetic unit.
// Depends on nothing; included by the modules that carry assertions.
`ifndef RATIONAL_ARITH_UNIT_TOP_MACROS_SVH
`define RATIONAL_ARITH_UNIT_TOP_MACROS_SVH

// Condition true in a cycle implies the consequence in the same cycle.
`define RAU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Condition true in a cycle implies the consequence in the next cycle.
`define RAU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ design/rau_pkg.sv @@
// Package of the rational arithmetic unit: op codes, multiplier selects, states, command and status types.
// Depends on nothing.
package rau_pkg;

    localparam int IN_WIDTH_DEF = 32;

    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_CMP = 3'd4;
    localparam logic [2:0] OP_ABS = 3'd5;

    localparam logic [1:0] MSEL_P0 = 2'd0;
    localparam logic [1:0] MSEL_P1 = 2'd1;
    localparam logic [1:0] MSEL_P2 = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL0,
        ST_MUL1,
        ST_MUL2,
        ST_COMB,
        ST_GCD_TWO,
        ST_GCD_ODD,
        ST_DIV,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic       load;
        logic       mul_en;
        logic [1:0] mul_sel;
        logic       comb;
        logic       two_step;
        logic       odd_step;
        logic       div_init;
        logic       div_step;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic direct;
        logic both_even;
        logic xy_equal;
        logic div_last;
        logic out_full;
    } t_status;

endpackage

@@ design/rational_arith_unit_top.sv @@
// Top level of the rational arithmetic unit: stream ports, controller and datapath.
// Depends on rau_pkg, rau_ctrl and rau_datapath.
//
// Usage: one input transaction carries an op and two fractions a and b; one
// output transaction carries the reduced result and the compare/divide flags.
// The input is taken only while the unit is idle; the result then sits in an
// output register, so the next input is accepted while it waits to be taken.
// Each item passes the multiply states ST_MUL0, ST_MUL1 and ST_MUL2 on the one
// 32x32 multiplier, the combine state, then the binary gcd (one shift or
// subtract per step), then a restoring divide of numerator and denominator,
// and then goes to the output register. Compare, a zero result, a zero
// denominator, a zero divisor or an unused op skip the gcd and the divide.
// A new item is taken only once the last one has gone to the output register.
// Reset clears the controller and the output valid; no result is pending.
// When the receiver stalls, a finished result waits in the datapath, with the
// controller in ST_FIN, until the output register frees; no new input is taken.
module rational_arith_unit_top #(
    parameter int IN_WIDTH = rau_pkg::IN_WIDTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // a_num[31:0], a_den[62:32], b_num[94:63], b_den[125:95], zero pad
    input  logic [127:0] i_s_axis_tdata,
    // op[2:0]
    input  logic [2:0]   i_s_axis_tuser,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // res_num[63:0], res_den[125:64], zero pad
    output logic [127:0] o_m_axis_tdata,
    // less_flag[0], equal_flag[1], div_zero[2]
    output logic [2:0]   o_m_axis_tuser
);

    rau_pkg::t_cmd    cmd;
    rau_pkg::t_status status;
    logic [63:0]      res_num;
    logic [61:0]      res_den;
    logic             less_flag, equal_flag, div_zero;

    // Sequencer.
    rau_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // Arithmetic and output register.
    rau_datapath #(
        .IN_WIDTH (IN_WIDTH)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_op         (i_s_axis_tuser),
        .i_a_num      (i_s_axis_tdata[31:0]),
        .i_a_den      (i_s_axis_tdata[62:32]),
        .i_b_num      (i_s_axis_tdata[94:63]),
        .i_b_den      (i_s_axis_tdata[125:95]),
        .o_out_valid  (o_m_axis_tvalid),
        .i_out_ready  (i_m_axis_tready),
        .o_res_num    (res_num),
        .o_res_den    (res_den),
        .o_less_flag  (less_flag),
        .o_equal_flag (equal_flag),
        .o_div_zero   (div_zero)
    );

    // Output packing.
    assign o_m_axis_tdata = {2'b00, res_den, res_num};
    assign o_m_axis_tuser = {div_zero, equal_flag, less_flag};

endmodule

@@ design/rau_ctrl.sv @@
// Controller state machine of the rational arithmetic unit.
// Depends on rau_pkg and rational_arith_unit_top_macros.svh.
`include "rational_arith_unit_top_macros.svh"

module rau_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  rau_pkg::t_status i_status,
    output rau_pkg::t_cmd    o_cmd
);

    rau_pkg::t_state r_state;
    rau_pkg::t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rau_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            rau_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = rau_pkg::ST_MUL0;
                end
            end
            rau_pkg::ST_MUL0: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = rau_pkg::MSEL_P0;
                n_state       = rau_pkg::ST_MUL1;
            end
            rau_pkg::ST_MUL1: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = rau_pkg::MSEL_P1;
                n_state       = rau_pkg::ST_MUL2;
            end
            rau_pkg::ST_MUL2: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = rau_pkg::MSEL_P2;
                n_state       = rau_pkg::ST_COMB;
            end
            rau_pkg::ST_COMB: begin
                o_cmd.comb = 1'b1;
                n_state    = i_status.direct ? rau_pkg::ST_FIN : rau_pkg::ST_GCD_TWO;
            end
            rau_pkg::ST_GCD_TWO: begin
                if (i_status.both_even) begin
                    o_cmd.two_step = 1'b1;
                end else begin
                    n_state = rau_pkg::ST_GCD_ODD;
                end
            end
            rau_pkg::ST_GCD_ODD: begin
                if (i_status.xy_equal) begin
                    o_cmd.div_init = 1'b1;
                    n_state        = rau_pkg::ST_DIV;
                end else begin
                    o_cmd.odd_step = 1'b1;
                end
            end
            rau_pkg::ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = rau_pkg::ST_FIN;
                end
            end
            rau_pkg::ST_FIN: begin
                if (!i_status.out_full) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = rau_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = rau_pkg::ST_IDLE;
            end
        endcase
    end

    // A result is never written over one that waits.
    `RAU_ASSERT_NOW(a_no_overwrite, i_clk, i_rst_n, o_cmd.out_load, !i_status.out_full)
    // An accepted transaction starts the multiply sequence.
    `RAU_ASSERT_NEXT(a_load_mul, i_clk, i_rst_n, o_cmd.load, r_state == rau_pkg::ST_MUL0)
    // Equal gcd operands start the divide.
    `RAU_ASSERT_NEXT(a_gcd_div, i_clk, i_rst_n,
        (r_state == rau_pkg::ST_GCD_ODD) && i_status.xy_equal, r_state == rau_pkg::ST_DIV)

endmodule

@@ design/rau_datapath.sv @@
// Datapath of the rational arithmetic unit: multiplier, combine, binary gcd, divider, output.
// Depends on rau_pkg.
module rau_datapath #(
    parameter int IN_WIDTH = rau_pkg::IN_WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  rau_pkg::t_cmd    i_cmd,
    output rau_pkg::t_status o_status,
    input  logic [2:0]       i_op,
    input  logic [31:0]      i_a_num,
    input  logic [30:0]      i_a_den,
    input  logic [31:0]      i_b_num,
    input  logic [30:0]      i_b_den,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [63:0]      o_res_num,
    output logic [61:0]      o_res_den,
    output logic             o_less_flag,
    output logic             o_equal_flag,
    output logic             o_div_zero
);

    localparam int SH = 32 - IN_WIDTH;
    localparam logic [30:0] DEN_MASK = 31'((64'd1 << (IN_WIDTH - 1)) - 64'd1);

    logic [2:0]         r_op;
    logic signed [31:0] r_an, r_bn;
    logic [30:0]        r_ad, r_bd;
    logic signed [63:0] r_p0, r_p1, r_p2;
    logic [63:0]        r_x, r_y, r_mn, r_md;
    logic               r_neg;
    logic [63:0]        r_qn, r_qd, r_remn, r_remd;
    logic [5:0]         r_cnt;
    logic [63:0]        r_rn;
    logic [61:0]        r_rd;
    logic               r_lt, r_eq, r_dz;
    logic               r_out_valid;

    logic signed [31:0] an_ext, bn_ext;
    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] prod;
    logic signed [63:0] num, den;
    logic [63:0]        mn, md;
    logic               neg;
    logic [64:0]        tn, td;
    logic               bn_zero, no_reduce;

    // Input fields trimmed to the configured width.
    assign an_ext = $signed(i_a_num << SH) >>> SH;
    assign bn_ext = $signed(i_b_num << SH) >>> SH;

    // Operand selection for the shared multiplier.
    always_comb begin
        case (i_cmd.mul_sel)
            rau_pkg::MSEL_P0: begin
                mul_a = r_an;
                mul_b = (r_op == rau_pkg::OP_MUL) ? r_bn : $signed({1'b0, r_bd});
            end
            rau_pkg::MSEL_P1: begin
                mul_a = r_bn;
                mul_b = $signed({1'b0, r_ad});
            end
            default: begin
                mul_a = $signed({1'b0, r_ad});
                mul_b = $signed({1'b0, r_bd});
            end
        endcase
    end
    assign prod = mul_a * mul_b;

    // Unreduced numerator and denominator for each op.
    always_comb begin
        case (r_op)
            rau_pkg::OP_ADD: begin
                num = r_p0 + r_p1;
                den = r_p2;
            end
            rau_pkg::OP_SUB: begin
                num = r_p0 - r_p1;
                den = r_p2;
            end
            rau_pkg::OP_MUL: begin
                num = r_p0;
                den = r_p2;
            end
            rau_pkg::OP_DIV: begin
                num = r_p0;
                den = r_p1;
            end
            rau_pkg::OP_ABS: begin
                num = (r_an < 0) ? -64'(r_an) : 64'(r_an);
                den = 64'({1'b0, r_ad});
            end
            default: begin
                num = '0;
                den = 64'sd1;
            end
        endcase
    end
    assign neg       = num[63] ^ den[63];
    assign mn        = num[63] ? (64'd0 - num) : num;
    assign md        = den[63] ? (64'd0 - den) : den;
    assign bn_zero   = (r_bn == 32'sd0);
    assign no_reduce = (r_op == rau_pkg::OP_CMP) || (r_op > rau_pkg::OP_ABS) ||
                       ((r_op == rau_pkg::OP_DIV) && bn_zero);

    // One restoring-division step for both quotients against the odd gcd.
    assign tn = {r_remn, r_qn[63]};
    assign td = {r_remd, r_qd[63]};

    assign o_status.direct    = no_reduce || (mn == 64'd0) || (md == 64'd0);
    assign o_status.both_even = !r_x[0] && !r_y[0];
    assign o_status.xy_equal  = (r_x == r_y);
    assign o_status.div_last  = (r_cnt == 6'd63);
    assign o_status.out_full  = r_out_valid;

    // Operand capture and multiplier products.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op <= i_op;
            r_an <= an_ext;
            r_bn <= bn_ext;
            r_ad <= i_a_den & DEN_MASK;
            r_bd <= i_b_den & DEN_MASK;
        end
        if (i_cmd.mul_en) begin
            case (i_cmd.mul_sel)
                rau_pkg::MSEL_P0: r_p0 <= prod;
                rau_pkg::MSEL_P1: r_p1 <= prod;
                default:          r_p2 <= prod;
            endcase
        end
    end

    // Combine, gcd and division working registers, and the pending result.
    always_ff @(posedge i_clk) begin
        if (i_cmd.comb) begin
            r_x   <= mn;
            r_y   <= md;
            r_mn  <= mn;
            r_md  <= md;
            r_neg <= neg;
            r_lt  <= (r_op == rau_pkg::OP_CMP) && (r_p0 < r_p1);
            r_eq  <= (r_op == rau_pkg::OP_CMP) && (r_p0 == r_p1);
            r_dz  <= (r_op == rau_pkg::OP_DIV) && bn_zero;
            if (no_reduce || (mn == 64'd0)) begin
                r_rn <= 64'd0;
                r_rd <= 62'd1;
            end else begin
                r_rn <= neg ? {64{1'b1}} : 64'd1;
                r_rd <= 62'd0;
            end
        end
        // Shared factors of two come off both values and the dividends.
        if (i_cmd.two_step) begin
            r_x  <= r_x >> 1;
            r_y  <= r_y >> 1;
            r_mn <= r_mn >> 1;
            r_md <= r_md >> 1;
        end
        if (i_cmd.odd_step) begin
            if (!r_x[0]) begin
                r_x <= r_x >> 1;
            end else if (!r_y[0]) begin
                r_y <= r_y >> 1;
            end else if (r_x > r_y) begin
                r_x <= (r_x - r_y) >> 1;
            end else begin
                r_y <= (r_y - r_x) >> 1;
            end
        end
        if (i_cmd.div_init) begin
            r_qn   <= r_mn;
            r_qd   <= r_md;
            r_remn <= '0;
            r_remd <= '0;
            r_cnt  <= '0;
        end
        if (i_cmd.div_step) begin
            r_cnt <= r_cnt + 6'd1;
            if (tn >= {1'b0, r_x}) begin
                r_remn <= 64'(tn - {1'b0, r_x});
                r_qn   <= {r_qn[62:0], 1'b1};
            end else begin
                r_remn <= tn[63:0];
                r_qn   <= {r_qn[62:0], 1'b0};
            end
            if (td >= {1'b0, r_x}) begin
                r_remd <= 64'(td - {1'b0, r_x});
                r_qd   <= {r_qd[62:0], 1'b1};
            end else begin
                r_remd <= td[63:0];
                r_qd   <= {r_qd[62:0], 1'b0};
            end
            if (o_status.div_last) begin
                r_rn <= r_neg ? (64'd0 - {r_qn[62:0], tn >= {1'b0, r_x}})
                              : {r_qn[62:0], tn >= {1'b0, r_x}};
                r_rd <= {r_qd[60:0], td >= {1'b0, r_x}};
            end
        end
    end

    // Output register holding one result transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_res_num    <= r_rn;
            o_res_den    <= r_rd;
            o_less_flag  <= r_lt;
            o_equal_flag <= r_eq;
            o_div_zero   <= r_dz;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule
